// File: design/life_like_cellular_automaton_top_defines.svh
// Assertion macros used by the top level of the cellular automaton block.
`ifndef LIFE_LIKE_CELLULAR_AUTOMATON_TOP_DEFINES_SVH
`define LIFE_LIKE_CELLULAR_AUTOMATON_TOP_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define LLCA_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define LLCA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/llca_pkg.sv
// Types, constants and rule tables of the cellular automaton block.
package llca_pkg;

	localparam int MAX_COLS  = 64;
	localparam int MAX_ROWS  = 64;
	localparam int ROW_W     = 6;
	localparam int COL_W     = 6;
	localparam int DIM_W     = 7;
	localparam int RULE_W    = 5;
	localparam int NRULES    = 20;
	localparam int CFG_W     = 7;
	localparam int CFG_AW    = 2;
	localparam int IN_W      = 16;
	localparam int OUT_W     = 8;
	localparam int RAM_DEPTH = 2 * MAX_ROWS;
	localparam int RAM_AW    = $clog2(RAM_DEPTH);
	localparam int CNT_W     = 4;
	localparam int MASK_W    = 9;

	localparam logic [DIM_W-1:0] DIM_RESET = 7'd10;

	localparam logic [CFG_AW-1:0] CFG_RULE   = 2'd0;
	localparam logic [CFG_AW-1:0] CFG_WIDTH  = 2'd1;
	localparam logic [CFG_AW-1:0] CFG_HEIGHT = 2'd2;

	typedef enum logic [1:0] {
		ACT_WRITE = 2'd0,
		ACT_READ  = 2'd1,
		ACT_STEP  = 2'd2,
		ACT_NOP   = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_CELL,
		ST_STEP,
		ST_SWAP,
		ST_RESP
	} ctrl_state_t;

	typedef struct packed {
		logic load_item;
		logic clr_wr;
		logic cell_wr;
		logic step_start;
		logic step_run;
		logic swap;
		logic res_cap;
		logic out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		action_t action;
		logic    in_range;
		logic    step_skip;
		logic    step_done;
		logic    clr_last;
	} dp_stat_t;

	// bit n set: a live cell with n live neighbors stays alive
	function automatic logic [MASK_W-1:0] survive_mask(input logic [RULE_W-1:0] rule);
		logic [MASK_W-1:0] m;
		unique case (rule)
			5'd0:                                  m = 9'b000001100;
			5'd1, 5'd2:                            m = 9'b000011100;
			5'd3:                                  m = 9'b000001110;
			5'd4, 5'd5:                            m = 9'b000111000;
			5'd6:                                  m = 9'b001110000;
			5'd7, 5'd9, 5'd10, 5'd11, 5'd12, 5'd13: m = 9'b111110000;
			5'd8, 5'd15, 5'd16, 5'd17, 5'd18, 5'd19: m = 9'b011110000;
			5'd14:                                 m = 9'b000001111;
			default:                               m = '0;
		endcase
		return m;
	endfunction

	// bit n set: a dead cell with n live neighbors comes alive
	function automatic logic [MASK_W-1:0] birth_mask(input logic [RULE_W-1:0] rule);
		logic [MASK_W-1:0] m;
		unique case (rule)
			5'd0, 5'd1, 5'd5:        m = 9'b000001000;
			5'd2, 5'd3, 5'd4:        m = 9'b000000100;
			5'd6, 5'd7, 5'd8:        m = 9'b111111000;
			5'd10, 5'd17:            m = 9'b100000000;
			5'd11, 5'd16:            m = 9'b110000000;
			5'd12, 5'd15:            m = 9'b111000000;
			5'd13, 5'd14:            m = 9'b111100000;
			default:                 m = '0;
		endcase
		return m;
	endfunction

endpackage

// File: design/life_like_cellular_automaton_top.sv
// Top level of the life-like cellular automaton block.
//
//   channel   dir  handshake                      payload
//   s_axis    in   s_axis_tvalid/s_axis_tready    action, row, col, cell_in
//   m_axis    out  m_axis_tvalid/m_axis_tready    cell_out, index_error
//   cfg       in   cfg_we                         cfg_addr, cfg_wdata
//
// Cell write/read: decode, cell and response states; out-of-range or unused action skips the cell state.
// Step: one grid row per cycle through the row-wide memory and
// a three-row window; an unused rule or an empty grid only swaps the grids.
// After reset a clearing pass zeroes both grids; s_axis_tready stays low
// meanwhile. A stalled result holds in the output register while the
// next transaction is taken; the result of that one waits until it drains.
`include "life_like_cellular_automaton_top_defines.svh"

module life_like_cellular_automaton_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [llca_pkg::CFG_AW-1:0]  cfg_addr,
	input  logic [llca_pkg::CFG_W-1:0]   cfg_wdata,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	// [1:0] action, [7:2] row, [13:8] col, [14] cell_in, [15] zero
	input  logic [llca_pkg::IN_W-1:0]    s_axis_tdata,
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// [0] cell_out, [1] index_error, [7:2] zero
	output logic [llca_pkg::OUT_W-1:0]   m_axis_tdata
);
	import llca_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	llca_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.stat         (stat),
		.cmd          (cmd)
	);

	llca_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.in_data  (s_axis_tdata),
		.out_data (m_axis_tdata),
		.cmd      (cmd),
		.stat     (stat)
	);

	`LLCA_ASSERT_SAME(a_no_overwrite, cmd.out_load, !m_axis_tvalid || m_axis_tready, "result overwritten")
	`LLCA_ASSERT_NEXT(a_load_shows, cmd.out_load, m_axis_tvalid, "loaded result not shown")
	`LLCA_ASSERT_NEXT(a_step_swaps, stat.step_done, cmd.swap, "step end without swap")
	`LLCA_ASSERT_SAME(a_idle_no_step, s_axis_tready, !cmd.step_run && !cmd.clr_wr, "ready while busy")

endmodule

// File: design/llca_ram.sv
// Generic memory: one write port, two registered read ports.
module llca_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// File: design/llca_ctrl.sv
// Controller state machine: clearing pass, item sequencing and result handshake.
module llca_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	input  llca_pkg::dp_stat_t    stat,
	output llca_pkg::ctrl_cmd_t   cmd
);
	import llca_pkg::*;

	ctrl_state_t state_q, state_d;
	logic        out_valid_q;
	logic        out_free;

	assign out_free      = !out_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (stat.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (s_axis_tvalid) state_d = ST_DECODE;
			end
			ST_DECODE: begin
				unique case (stat.action)
					ACT_WRITE, ACT_READ: state_d = stat.in_range ? ST_CELL : ST_RESP;
					ACT_STEP:            state_d = stat.step_skip ? ST_SWAP : ST_STEP;
					default:             state_d = ST_RESP;
				endcase
			end
			ST_CELL: begin
				state_d = ST_RESP;
			end
			ST_STEP: begin
				if (stat.step_done) state_d = ST_SWAP;
			end
			ST_SWAP: begin
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_CLEAR: cmd.clr_wr = 1'b1;
			ST_IDLE:  cmd.load_item = s_axis_tvalid;
			ST_DECODE: begin
				unique case (stat.action)
					ACT_WRITE, ACT_READ: cmd.res_cap = !stat.in_range;
					ACT_STEP:            cmd.step_start = !stat.step_skip;
					default:             cmd.res_cap = 1'b1;
				endcase
			end
			ST_CELL: begin
				cmd.cell_wr = (stat.action == ACT_WRITE);
				cmd.res_cap = 1'b1;
			end
			ST_STEP:  cmd.step_run = 1'b1;
			ST_SWAP: begin
				cmd.swap    = 1'b1;
				cmd.res_cap = 1'b1;
			end
			ST_RESP:  cmd.out_load = out_free;
			default:  cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: design/llca_dp.sv
// Datapath: configuration, grid memory, row window and next-generation logic.
module llca_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [llca_pkg::CFG_AW-1:0]   cfg_addr,
	input  logic [llca_pkg::CFG_W-1:0]    cfg_wdata,
	input  logic [llca_pkg::IN_W-1:0]     in_data,
	output logic [llca_pkg::OUT_W-1:0]    out_data,
	input  llca_pkg::ctrl_cmd_t           cmd,
	output llca_pkg::dp_stat_t            stat
);
	import llca_pkg::*;

	// configuration
	logic [RULE_W-1:0] rule_q;
	logic [DIM_W-1:0]  width_q, height_q;
	logic [DIM_W-1:0]  used_cols, used_rows;

	// latched item
	action_t           action_q;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;
	logic              cell_q;

	logic              act_q;
	logic [RAM_AW-1:0] clr_q;
	logic [DIM_W-1:0]  rd_q, rd_m1;
	logic              arr_vld_s1;
	logic [DIM_W-1:0]  arr_tag_s1, tag_m1;

	logic [MAX_COLS-1:0] up_q, mid_q, dn_row, colmask, gen_row, cell_row;
	logic [MAX_COLS+1:0] pu, pm, pd;
	logic [MASK_W-1:0]   surv, birth;
	logic [CNT_W-1:0]    cnt [MAX_COLS];
	logic [1:0]          res_d, res_q, out_q;
	logic                in_range;

	logic                ram_we;
	logic [RAM_AW-1:0]   ram_waddr, ram_raddr_a, ram_raddr_b;
	logic [MAX_COLS-1:0] ram_wdata, ram_qa, ram_qb;

	assign used_cols = (width_q > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : width_q;
	assign used_rows = (height_q > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : height_q;
	assign in_range  = ({1'b0, row_q} < used_rows) && ({1'b0, col_q} < used_cols);

	assign rd_m1  = rd_q - DIM_W'(1);
	assign tag_m1 = arr_tag_s1 - DIM_W'(1);

	assign stat.action    = action_q;
	assign stat.in_range  = in_range;
	assign stat.step_skip = (rule_q >= RULE_W'(NRULES)) || (used_rows == '0)
		|| (used_cols == '0);
	assign stat.step_done = arr_vld_s1 && (arr_tag_s1 == used_rows);
	assign stat.clr_last  = (clr_q == RAM_AW'(RAM_DEPTH - 1));

	always_comb begin
		for (int c = 0; c < MAX_COLS; c++) begin
			colmask[c] = (DIM_W'(c) < used_cols);
		end
	end

	// row below the one being generated; rows past the grid count as dead
	assign dn_row = (arr_tag_s1 < used_rows) ? (ram_qa & colmask) : '0;
	assign pu     = {1'b0, up_q, 1'b0};
	assign pm     = {1'b0, mid_q, 1'b0};
	assign pd     = {1'b0, dn_row, 1'b0};
	assign surv   = survive_mask(rule_q);
	assign birth  = birth_mask(rule_q);

	always_comb begin
		for (int c = 0; c < MAX_COLS; c++) begin
			cnt[c] = {3'b0, pu[c]} + {3'b0, pu[c+1]} + {3'b0, pu[c+2]}
				+ {3'b0, pm[c]} + {3'b0, pm[c+2]}
				+ {3'b0, pd[c]} + {3'b0, pd[c+1]} + {3'b0, pd[c+2]};
			gen_row[c] = mid_q[c] ? surv[cnt[c]] : birth[cnt[c]];
		end
	end

	always_comb begin
		cell_row        = ram_qa;
		cell_row[col_q] = cell_q;
	end

	// memory holds both grids: bank bit on top, row index below
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = {act_q, row_q};
		ram_wdata = cell_row;
		if (cmd.clr_wr) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else if (cmd.cell_wr) begin
			ram_we = 1'b1;
		end else if (arr_vld_s1 && (arr_tag_s1 != '0)) begin
			ram_we    = 1'b1;
			ram_waddr = {~act_q, tag_m1[ROW_W-1:0]};
			ram_wdata = (gen_row & colmask) | (ram_qb & ~colmask);
		end
	end

	assign ram_raddr_a = cmd.step_run ? {act_q, rd_q[ROW_W-1:0]} : {act_q, row_q};
	assign ram_raddr_b = {~act_q, rd_m1[ROW_W-1:0]};

	llca_ram #(
		.WIDTH(MAX_COLS),
		.DEPTH(RAM_DEPTH)
	) u_grid_ram (
		.clk    (clk),
		.we     (ram_we),
		.waddr  (ram_waddr),
		.wdata  (ram_wdata),
		.raddr_a(ram_raddr_a),
		.rdata_a(ram_qa),
		.raddr_b(ram_raddr_b),
		.rdata_b(ram_qb)
	);

	always_comb begin
		res_d[0] = (action_q == ACT_READ) && in_range && ram_qa[col_q];
		res_d[1] = ((action_q == ACT_WRITE) || (action_q == ACT_READ)) && !in_range;
	end

	assign out_data = {{(OUT_W - 2){1'b0}}, out_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rule_q     <= '0;
			width_q    <= DIM_RESET;
			height_q   <= DIM_RESET;
			act_q      <= 1'b0;
			clr_q      <= '0;
			rd_q       <= '0;
			arr_vld_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					CFG_RULE:   rule_q   <= cfg_wdata[RULE_W-1:0];
					CFG_WIDTH:  width_q  <= cfg_wdata;
					CFG_HEIGHT: height_q <= cfg_wdata;
					default:    ;
				endcase
			end
			if (cmd.clr_wr) clr_q <= clr_q + RAM_AW'(1);
			if (cmd.swap) act_q <= ~act_q;
			if (cmd.step_start) begin
				rd_q <= '0;
			end else if (cmd.step_run && (rd_q <= used_rows)) begin
				rd_q <= rd_q + DIM_W'(1);
			end
			arr_vld_s1 <= cmd.step_run && (rd_q <= used_rows);
		end
	end

	always_ff @(posedge clk) begin
		arr_tag_s1 <= rd_q;
		if (cmd.load_item) begin
			action_q <= action_t'(in_data[1:0]);
			row_q    <= in_data[7:2];
			col_q    <= in_data[13:8];
			cell_q   <= in_data[14];
		end
		if (cmd.step_start) begin
			up_q  <= '0;
			mid_q <= '0;
		end else if (arr_vld_s1) begin
			up_q  <= mid_q;
			mid_q <= dn_row;
		end
		if (cmd.res_cap) res_q <= res_d;
		if (cmd.out_load) out_q <= res_q;
	end

endmodule

// File: tb/life_like_cellular_automaton_top_tb.sv
// Self-checking testbench for the life-like cellular automaton block.
`timescale 1ns / 100ps

module life_like_cellular_automaton_top_tb;
	import llca_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE      = 10;
	localparam int HOLD_LEN    = 300;
	localparam int GRID_CELLS  = MAX_ROWS * MAX_COLS;

	// bit n: a live cell with n live neighbors stays alive
	localparam logic [8:0] STAY_MASK [NRULES] = '{
		9'b000001100, 9'b000011100, 9'b000011100, 9'b000001110, 9'b000111000,
		9'b000111000, 9'b001110000, 9'b111110000, 9'b011110000, 9'b111110000,
		9'b111110000, 9'b111110000, 9'b111110000, 9'b111110000, 9'b000001111,
		9'b011110000, 9'b011110000, 9'b011110000, 9'b011110000, 9'b011110000
	};
	// bit n: a dead cell with n live neighbors comes alive
	localparam logic [8:0] BORN_MASK [NRULES] = '{
		9'b000001000, 9'b000001000, 9'b000000100, 9'b000000100, 9'b000000100,
		9'b000001000, 9'b111111000, 9'b111111000, 9'b111111000, 9'b000000000,
		9'b100000000, 9'b110000000, 9'b111000000, 9'b111100000, 9'b111100000,
		9'b111000000, 9'b110000000, 9'b100000000, 9'b000000000, 9'b000000000
	};

	typedef struct packed {
		logic       pad;
		logic       cell_in;
		logic [5:0] col;
		logic [5:0] row;
		action_t    action;
	} ca_item_t;

	typedef struct packed {
		logic [5:0] pad;
		logic       index_error;
		logic       cell_out;
	} ca_reply_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [CFG_AW-1:0] cfg_addr = '0;
	logic [CFG_W-1:0]  cfg_wdata = '0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [IN_W-1:0]   s_axis_tdata = '0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [OUT_W-1:0]  m_axis_tdata;

	life_like_cellular_automaton_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #5 clk = ~clk;

	// predictor state
	bit          board [2][GRID_CELLS];
	int          live_side = 0;
	logic [4:0]  rule_sel = 5'd0;
	logic [6:0]  cols_cfg = 7'd10;
	logic [6:0]  rows_cfg = 7'd10;

	ca_item_t    pending_items[$];
	ca_reply_t   expected_replies[$];

	int          items_queued = 0;
	int          items_taken = 0;
	int          replies_seen = 0;
	int          generations = 0;
	int          flagged = 0;
	int          mismatches = 0;
	int          phases = 0;
	int          cycles = 0;
	bit          offer_open = 0;
	bit          steady = 0;
	bit          hold_go = 0;
	int          hold_left = 0;
	int          tx_gap = 0;
	int          rx_gap = 0;

	function automatic int clamp_dim(input logic [6:0] d);
		return (d > 7'd64) ? 64 : int'(d);
	endfunction

	function automatic int pick_gap();
		int k;
		k = $urandom_range(0, 99);
		if (steady || k < 55)
			return 0;
		if (k < 88)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic flag_mismatch(input string what, input int got, input int want);
		mismatches++;
		$display("MISMATCH @%0t reply %0d: %0s got %0d want %0d",
			$realtime, replies_seen, what, got, want);
	endtask

	task automatic next_generation();
		int ew, eh, src, dst, n, y, x, dy, dx, ny, nx;
		logic [8:0] m;
		ew = clamp_dim(cols_cfg);
		eh = clamp_dim(rows_cfg);
		src = live_side;
		dst = 1 - live_side;
		if (rule_sel < NRULES) begin
			for (y = 0; y < eh; y++) begin
				for (x = 0; x < ew; x++) begin
					n = 0;
					for (dy = -1; dy <= 1; dy++) begin
						for (dx = -1; dx <= 1; dx++) begin
							ny = y + dy;
							nx = x + dx;
							if ((dy != 0 || dx != 0) && ny >= 0 && nx >= 0 &&
								ny < eh && nx < ew)
								n += board[src][ny * MAX_COLS + nx];
						end
					end
					m = board[src][y * MAX_COLS + x] ? STAY_MASK[rule_sel]
						: BORN_MASK[rule_sel];
					board[dst][y * MAX_COLS + x] = m[n];
				end
			end
		end
		live_side = dst;
	endtask

	task automatic predict_item(input ca_item_t it);
		ca_reply_t r;
		int idx;
		r = '0;
		case (it.action)
			ACT_WRITE, ACT_READ: begin
				if (int'(it.row) >= clamp_dim(rows_cfg) || int'(it.col) >= clamp_dim(cols_cfg)) begin
					r.index_error = 1'b1;
					flagged++;
				end else begin
					idx = int'(it.row) * MAX_COLS + int'(it.col);
					if (it.action == ACT_WRITE)
						board[live_side][idx] = it.cell_in;
					else
						r.cell_out = board[live_side][idx];
				end
			end
			ACT_STEP: begin
				next_generation();
				generations++;
			end
			default: ;
		endcase
		expected_replies.push_back(r);
	endtask

	task automatic check_reply(input logic [OUT_W-1:0] got_bits);
		ca_reply_t got, want;
		got = ca_reply_t'(got_bits);
		replies_seen++;
		if (expected_replies.size() == 0) begin
			flag_mismatch("unexpected transaction, data", int'(got_bits), -1);
		end else begin
			want = expected_replies.pop_front();
			if (got.cell_out !== want.cell_out)
				flag_mismatch("cell_out", int'(got.cell_out), int'(want.cell_out));
			if (got.index_error !== want.index_error)
				flag_mismatch("index_error", int'(got.index_error), int'(want.index_error));
			if (got.pad !== want.pad)
				flag_mismatch("padding", int'(got.pad), 0);
		end
	endtask

	// monitor: replies are checked before the input of the same edge is predicted
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				check_reply(m_axis_tdata);
			if (s_axis_tvalid && s_axis_tready) begin
				predict_item(ca_item_t'(s_axis_tdata));
				offer_open = 0;
				items_taken++;
			end
		end
	end

	// input driver
	always @(negedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!offer_open) begin
			if (tx_gap > 0) begin
				tx_gap--;
				s_axis_tvalid <= 1'b0;
			end else if (pending_items.size() > 0) begin
				s_axis_tdata  <= pending_items.pop_front();
				s_axis_tvalid <= 1'b1;
				offer_open = 1;
				tx_gap = pick_gap();
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// output backpressure
	always @(negedge clk) begin
		if (!arst_n || hold_left > 0) begin
			m_axis_tready <= 1'b0;
		end else if (rx_gap > 0) begin
			rx_gap--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
			rx_gap = pick_gap();
		end
	end

	// long receiver hold-off
	always @(posedge clk) begin
		if (hold_go) begin
			hold_go = 0;
			hold_left = HOLD_LEN;
		end else if (hold_left > 0) begin
			hold_left--;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles: %0d of %0d items taken, %0d replies pending",
				cycles, items_taken, items_queued, expected_replies.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic queue_item(input action_t a, input int r, input int c, input bit v);
		ca_item_t it;
		it = '0;
		it.action = a;
		it.row = r[5:0];
		it.col = c[5:0];
		it.cell_in = v;
		pending_items.push_back(it);
		items_queued++;
	endtask

	function automatic ca_item_t random_item();
		ca_item_t it;
		int ew, eh, k;
		ew = clamp_dim(cols_cfg);
		eh = clamp_dim(rows_cfg);
		k = $urandom_range(0, 99);
		it = '0;
		it.cell_in = ($urandom_range(0, 9) < 6);
		it.row = 6'($urandom_range(0, 63));
		it.col = 6'($urandom_range(0, 63));
		if (k < 85 && ew > 0 && eh > 0) begin
			it.row = 6'($urandom_range(0, eh - 1));
			it.col = 6'($urandom_range(0, ew - 1));
		end
		if (k < 45) begin
			it.action = ACT_WRITE;
		end else if (k < 75) begin
			it.action = ACT_READ;
		end else if (k < 85) begin
			it.action = ACT_STEP;
		end else if (k < 95) begin
			it.action = k[0] ? ACT_READ : ACT_WRITE;
			if (eh < 64 && (ew == 64 || $urandom_range(0, 1)))
				it.row = 6'($urandom_range(eh, 63));
			else if (ew < 64)
				it.col = 6'($urandom_range(ew, 63));
		end else begin
			it.action = ACT_NOP;
		end
		return it;
	endfunction

	task automatic wait_idle();
		while (items_taken != items_queued || expected_replies.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_AW-1:0] addr, input int value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= addr;
		cfg_wdata <= value[CFG_W-1:0];
		case (addr)
			CFG_RULE:   rule_sel = value[4:0];
			CFG_WIDTH:  cols_cfg = value[6:0];
			CFG_HEIGHT: rows_cfg = value[6:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(input int rule, input int w, input int h, input int n_items);
		int i;
		wait_idle();
		write_reg(CFG_RULE, rule);
		write_reg(CFG_WIDTH, w);
		write_reg(CFG_HEIGHT, h);
		phases++;
		for (i = 0; i < n_items; i++) begin
			pending_items.push_back(random_item());
			items_queued++;
		end
	endtask

	initial begin
		int i, w, h;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: classic rule on a 10x10 grid
		queue_item(ACT_READ, 0, 0, 0);
		queue_item(ACT_WRITE, 0, 4, 1);     // blinker against the top edge
		queue_item(ACT_WRITE, 0, 5, 1);
		queue_item(ACT_WRITE, 0, 6, 1);
		queue_item(ACT_WRITE, 9, 9, 1);     // L shape in the far corner
		queue_item(ACT_WRITE, 9, 8, 1);
		queue_item(ACT_WRITE, 8, 9, 1);
		queue_item(ACT_WRITE, 10, 0, 1);    // out of range rows and cols
		queue_item(ACT_READ, 0, 10, 0);
		queue_item(ACT_WRITE, 63, 63, 1);
		queue_item(ACT_NOP, 63, 63, 1);
		queue_item(ACT_STEP, 0, 0, 0);
		queue_item(ACT_READ, 1, 5, 0);
		queue_item(ACT_READ, 0, 4, 0);
		queue_item(ACT_READ, 8, 8, 0);
		queue_item(ACT_READ, 9, 9, 0);
		queue_item(ACT_STEP, 63, 63, 1);
		queue_item(ACT_READ, 0, 5, 0);
		queue_item(ACT_WRITE, 9, 9, 0);
		queue_item(ACT_READ, 9, 9, 0);
		queue_item(ACT_NOP, 0, 0, 0);
		phases++;

		run_phase(7, 64, 64, 16);           // full grid
		run_phase(14, 1, 1, 10);            // single cell
		run_phase(3, 0, 5, 8);              // no columns in use
		run_phase(25, 127, 100, 10);        // clamped size, unused rule
		run_phase(31, 3, 0, 8);             // no rows in use, top rule index

		// backpressure: output held off while the input keeps coming
		run_phase($urandom_range(0, NRULES - 1), 8, 8, 24);
		steady = 1;
		hold_go = 1;
		wait_idle();
		steady = 0;

		for (i = 0; i < 6; i++) begin
			w = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 64) : $urandom_range(2, 12);
			h = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 64) : $urandom_range(2, 12);
			run_phase(($urandom_range(0, 7) == 0) ? $urandom_range(NRULES, 31)
				: $urandom_range(0, NRULES - 1), w, h, 8);
		end

		wait_idle();
		if (expected_replies.size() != 0)
			flag_mismatch("replies left over", expected_replies.size(), 0);
		$display("covered %0d phases, %0d transactions in, %0d out", phases, items_taken,
			replies_seen);
		$display("  %0d generations stepped, %0d out-of-range accesses flagged", generations,
			flagged);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
